// ----- hdl/smc_pkg.sv -----
`timescale 1ns / 1ps
package smc_pkg;

	localparam int RAM_WORDS     = 64;
	localparam int DISK_WORDS    = 128;
	localparam int NUM_PROCS     = 4;
	localparam int WORD_BITS     = 32;
	localparam int SWAP_OVERHEAD = 7;

	localparam int KIND_W   = 3;
	localparam int ID_W     = 3;
	localparam int ADDR_W   = 7;
	localparam int FIELD_W  = 6;
	localparam int SLOT_W   = 7;
	localparam int STATUS_W = 3;
	localparam int DATA_W   = 32;

	localparam int RAM_AW  = $clog2(RAM_WORDS);
	localparam int DISK_AW = $clog2(DISK_WORDS);
	localparam int PID_W   = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
	localparam int SCAN_W  = ((DISK_AW > RAM_AW) ? DISK_AW : RAM_AW) + 1;
	localparam int SRC_W   = $clog2(DISK_WORDS + SWAP_OVERHEAD + (1 << FIELD_W));
	localparam int CNT_W   = FIELD_W + 2;
	localparam int NEXT_W  = RAM_AW + 1;
	localparam int STEP_W  = PID_W + 1;

	typedef enum logic [KIND_W-1:0] {
		K_WRITE_RAM = 3'd0,
		K_READ_RAM  = 3'd1,
		K_READ_DISK = 3'd2,
		K_SET_PROC  = 3'd3,
		K_SWAP_OUT  = 3'd4,
		K_SWAP_IN   = 3'd5,
		K_COMPACT   = 3'd6,
		K_QUERY     = 3'd7
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 3'd0,
		ST_RESIDENT     = 3'd1,
		ST_NOT_RESIDENT = 3'd2,
		ST_NO_SPACE     = 3'd3,
		ST_DISK_FULL    = 3'd4,
		ST_BAD          = 3'd5
	} st_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_WRITE_RAM,
		CMD_SET_PROC,
		CMD_SCAN_START,
		CMD_SCAN_STEP,
		CMD_SO_BEGIN,
		CMD_SI_BEGIN,
		CMD_COPY_RD,
		CMD_COPY_WR,
		CMD_CLEAR,
		CMD_CMP_START,
		CMD_CMP_MOVE,
		CMD_RESULT
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
		logic    st_we;
		st_t     st_code;
	} dp_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  id_ok;
		logic  ram_addr_ok;
		logic  disk_addr_ok;
		logic  region_ok;
		logic  resident;
		logic  slot_valid;
		logic  scan_free;
		logic  scan_last;
		logic  scan_fits;
		logic  cnt_last;
		logic  clr_done;
		logic  cmp_found;
		logic  cmp_move;
		logic  cmp_done;
	} dp_flags_t;

endpackage

// ----- hdl/smc_datapath.sv -----
`timescale 1ns / 1ps
module smc_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  smc_pkg::dp_cmd_t            cmd,
	output smc_pkg::dp_flags_t          flags,
	input  logic [smc_pkg::KIND_W-1:0]  kind,
	input  logic [smc_pkg::ID_W-1:0]    proc_id,
	input  logic [smc_pkg::ADDR_W-1:0]  word_address,
	input  logic [smc_pkg::DATA_W-1:0]  word_data,
	input  logic [smc_pkg::FIELD_W-1:0] region_first,
	input  logic [smc_pkg::FIELD_W-1:0] region_last,
	input  logic [smc_pkg::FIELD_W-1:0] counter_in,
	input  logic [smc_pkg::FIELD_W-1:0] code_lines,
	output logic [smc_pkg::STATUS_W-1:0] status,
	output logic [smc_pkg::DATA_W-1:0]  read_value,
	output logic [smc_pkg::SLOT_W-1:0]  slot_index,
	output logic [smc_pkg::FIELD_W-1:0] start_out,
	output logic [smc_pkg::FIELD_W-1:0] end_out,
	output logic [smc_pkg::FIELD_W-1:0] counter_out,
	output logic                        in_ram
);
	import smc_pkg::*;

	kind_t               kind_q;
	logic [ID_W-1:0]     pid_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [WORD_BITS-1:0] data_q;
	logic [FIELD_W-1:0]  first_q, last_q, ctr_in_q, lines_q;

	logic [WORD_BITS-1:0] ram_mem [RAM_WORDS];
	logic [WORD_BITS-1:0] disk_mem [DISK_WORDS];
	logic [RAM_WORDS-1:0]  ram_occ_q;
	logic [DISK_WORDS-1:0] disk_occ_q;
	logic [WORD_BITS-1:0] ram_rd_q, disk_rd_q;
	logic                 ram_rd_occ_q, disk_rd_occ_q;

	logic [FIELD_W-1:0] t_start_q [NUM_PROCS];
	logic [FIELD_W-1:0] t_end_q   [NUM_PROCS];
	logic [FIELD_W-1:0] t_ctr_q   [NUM_PROCS];
	logic [SLOT_W-1:0]  t_slot_q  [NUM_PROCS];
	logic [NUM_PROCS-1:0] t_res_q, t_slotv_q;

	logic [SCAN_W-1:0]  ptr_q;
	logic [SRC_W-1:0]   src_q, dst_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [FIELD_W-1:0] end_q;
	logic [NEXT_W-1:0]  next_q;
	logic [STEP_W-1:0]  step_q;
	st_t                st_q;
	logic [SLOT_W-1:0]  slot_res_q;

	logic [PID_W-1:0]   pidx;
	logic [CNT_W-1:0]   size_p, need;
	logic               scan_disk, src_ok, report;
	logic [WORD_BITS-1:0] ram_eff, disk_eff;

	logic               best_found;
	logic [PID_W-1:0]   best_idx;
	logic [FIELD_W-1:0] best_start, best_end;
	logic [CNT_W-1:0]   best_size;

	logic [RAM_AW-1:0]    ram_ra, ram_wa;
	logic [DISK_AW-1:0]   disk_ra, disk_wa;
	logic                 ram_we, disk_we;
	logic [WORD_BITS-1:0] ram_wd, disk_wd;

	assign pidx      = PID_W'(pid_q - ID_W'(1));
	assign size_p    = CNT_W'(t_end_q[pidx]) - CNT_W'(t_start_q[pidx]) + CNT_W'(1);
	assign need      = CNT_W'(SWAP_OVERHEAD) + CNT_W'(lines_q);
	assign scan_disk = (kind_q == K_SWAP_OUT);
	assign src_ok    = 32'(src_q) < DISK_WORDS;
	assign ram_eff   = ram_rd_occ_q ? ram_rd_q : '0;
	assign disk_eff  = disk_rd_occ_q ? disk_rd_q : '0;
	assign report    = flags.id_ok && (kind_q == K_SET_PROC || kind_q == K_SWAP_OUT
		|| kind_q == K_SWAP_IN || kind_q == K_QUERY);

	always_comb begin
		best_found = 1'b0;
		best_idx   = '0;
		best_start = '0;
		for (int i = 0; i < NUM_PROCS; i++) begin
			if (t_res_q[i] && 32'(t_start_q[i]) >= 32'(next_q)
				&& (!best_found || t_start_q[i] < best_start)) begin
				best_found = 1'b1;
				best_idx   = PID_W'(i);
				best_start = t_start_q[i];
			end
		end
	end

	assign best_end  = t_end_q[best_idx];
	assign best_size = CNT_W'(best_end) - CNT_W'(best_start) + CNT_W'(1);

	always_comb begin
		flags.kind         = kind_q;
		flags.id_ok        = pid_q != '0 && 32'(pid_q) <= NUM_PROCS;
		flags.ram_addr_ok  = 32'(addr_q) < RAM_WORDS;
		flags.disk_addr_ok = 32'(addr_q) < DISK_WORDS;
		flags.region_ok    = first_q <= last_q && 32'(last_q) < RAM_WORDS;
		flags.resident     = t_res_q[pidx];
		flags.slot_valid   = t_slotv_q[pidx];
		flags.scan_free    = scan_disk ? !disk_occ_q[ptr_q[DISK_AW-1:0]]
			: !ram_occ_q[ptr_q[RAM_AW-1:0]];
		flags.scan_last    = scan_disk ? (32'(ptr_q) == DISK_WORDS - 1)
			: (32'(ptr_q) == RAM_WORDS - 1);
		flags.scan_fits    = scan_disk ? (32'(ptr_q) + 32'(size_p) <= DISK_WORDS)
			: (32'(ptr_q) + 32'(need) <= RAM_WORDS);
		flags.cnt_last     = cnt_q == CNT_W'(1);
		flags.clr_done     = 32'(dst_q) > 32'(end_q);
		flags.cmp_found    = best_found;
		flags.cmp_move     = 32'(best_start) != 32'(next_q);
		flags.cmp_done     = 32'(step_q) == NUM_PROCS;
	end

	always_comb begin
		ram_ra  = (cmd.op == CMD_COPY_RD) ? src_q[RAM_AW-1:0] : addr_q[RAM_AW-1:0];
		disk_ra = (cmd.op == CMD_COPY_RD) ? src_q[DISK_AW-1:0] : addr_q[DISK_AW-1:0];
		ram_we  = (cmd.op == CMD_WRITE_RAM) || (cmd.op == CMD_COPY_WR && !scan_disk);
		ram_wa  = (cmd.op == CMD_WRITE_RAM) ? addr_q[RAM_AW-1:0] : dst_q[RAM_AW-1:0];
		if (cmd.op == CMD_WRITE_RAM) begin
			ram_wd = data_q;
		end else if (kind_q == K_SWAP_IN) begin
			ram_wd = src_ok ? disk_eff : '0;
		end else begin
			ram_wd = ram_eff;
		end
		disk_we = (cmd.op == CMD_COPY_WR) && scan_disk;
		disk_wa = dst_q[DISK_AW-1:0];
		disk_wd = ram_eff;
	end

	always_ff @(posedge clk) begin
		ram_rd_q      <= ram_mem[ram_ra];
		ram_rd_occ_q  <= ram_occ_q[ram_ra];
		disk_rd_q     <= disk_mem[disk_ra];
		disk_rd_occ_q <= disk_occ_q[disk_ra];
		if (ram_we) begin
			ram_mem[ram_wa] <= ram_wd;
		end
		if (disk_we) begin
			disk_mem[disk_wa] <= disk_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_occ_q  <= '0;
			disk_occ_q <= '0;
		end else begin
			if (ram_we) begin
				ram_occ_q[ram_wa] <= |ram_wd;
			end
			if (cmd.op == CMD_COPY_WR && scan_disk) begin
				ram_occ_q[src_q[RAM_AW-1:0]] <= 1'b0;
			end
			if (cmd.op == CMD_CLEAR) begin
				ram_occ_q[dst_q[RAM_AW-1:0]] <= 1'b0;
			end
			if (disk_we) begin
				disk_occ_q[disk_wa] <= |disk_wd;
			end
			if (cmd.op == CMD_COPY_WR && kind_q == K_SWAP_IN && src_ok) begin
				disk_occ_q[src_q[DISK_AW-1:0]] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PROCS; i++) begin
				t_start_q[i] <= '0;
				t_end_q[i]   <= '0;
				t_ctr_q[i]   <= '0;
				t_slot_q[i]  <= '0;
			end
			t_res_q   <= '0;
			t_slotv_q <= '0;
		end else begin
			unique case (cmd.op)
				CMD_SET_PROC: begin
					t_start_q[pidx] <= first_q;
					t_end_q[pidx]   <= last_q;
					t_ctr_q[pidx]   <= ctr_in_q;
					t_res_q[pidx]   <= 1'b1;
					t_slot_q[pidx]  <= '0;
					t_slotv_q[pidx] <= 1'b0;
				end
				CMD_SO_BEGIN: begin
					t_ctr_q[pidx]   <= t_ctr_q[pidx] - t_start_q[pidx];
					t_start_q[pidx] <= '0;
					t_end_q[pidx]   <= '0;
					t_res_q[pidx]   <= 1'b0;
					t_slot_q[pidx]  <= SLOT_W'(ptr_q);
					t_slotv_q[pidx] <= 1'b1;
				end
				CMD_SI_BEGIN: begin
					t_start_q[pidx] <= FIELD_W'(ptr_q);
					t_end_q[pidx]   <= FIELD_W'(ptr_q) + FIELD_W'(need) - FIELD_W'(1);
					t_ctr_q[pidx]   <= FIELD_W'(ptr_q) + t_ctr_q[pidx];
					t_res_q[pidx]   <= 1'b1;
					t_slot_q[pidx]  <= '0;
					t_slotv_q[pidx] <= 1'b0;
				end
				CMD_CMP_MOVE: begin
					if (flags.cmp_move) begin
						t_start_q[best_idx] <= FIELD_W'(next_q);
						t_end_q[best_idx]   <= FIELD_W'(next_q) + FIELD_W'(best_size)
							- FIELD_W'(1);
						t_ctr_q[best_idx]   <= t_ctr_q[best_idx]
							- (best_start - FIELD_W'(next_q));
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.st_we) begin
			st_q <= cmd.st_code;
		end
		unique case (cmd.op)
			CMD_LOAD: begin
				kind_q     <= kind_t'(kind);
				pid_q      <= proc_id;
				addr_q     <= word_address;
				data_q     <= WORD_BITS'(word_data);
				first_q    <= region_first;
				last_q     <= region_last;
				ctr_in_q   <= counter_in;
				lines_q    <= code_lines;
				st_q       <= ST_OK;
				slot_res_q <= '0;
			end
			CMD_SCAN_START: begin
				ptr_q <= '0;
			end
			CMD_SCAN_STEP: begin
				ptr_q <= ptr_q + SCAN_W'(1);
			end
			CMD_SO_BEGIN: begin
				src_q      <= SRC_W'(t_start_q[pidx]);
				dst_q      <= SRC_W'(ptr_q);
				cnt_q      <= size_p;
				slot_res_q <= SLOT_W'(ptr_q);
			end
			CMD_SI_BEGIN: begin
				src_q      <= SRC_W'(t_slot_q[pidx]);
				dst_q      <= SRC_W'(ptr_q);
				cnt_q      <= need;
				slot_res_q <= SLOT_W'(ptr_q);
			end
			CMD_COPY_WR: begin
				src_q <= src_q + SRC_W'(1);
				dst_q <= dst_q + SRC_W'(1);
				cnt_q <= cnt_q - CNT_W'(1);
			end
			CMD_CLEAR: begin
				dst_q <= dst_q + SRC_W'(1);
			end
			CMD_CMP_START: begin
				next_q <= '0;
				step_q <= '0;
			end
			CMD_CMP_MOVE: begin
				src_q  <= SRC_W'(best_start);
				dst_q  <= SRC_W'(next_q);
				cnt_q  <= best_size;
				end_q  <= best_end;
				next_q <= next_q + NEXT_W'(best_size);
				step_q <= step_q + STEP_W'(1);
			end
			CMD_RESULT: begin
				status      <= st_q;
				slot_index  <= slot_res_q;
				start_out   <= report ? t_start_q[pidx] : '0;
				end_out     <= report ? t_end_q[pidx] : '0;
				counter_out <= report ? t_ctr_q[pidx] : '0;
				in_ram      <= report && t_res_q[pidx];
				if (st_q == ST_OK && kind_q == K_READ_RAM) begin
					read_value <= DATA_W'(ram_eff);
				end else if (st_q == ST_OK && kind_q == K_READ_DISK) begin
					read_value <= DATA_W'(disk_eff);
				end else begin
					read_value <= '0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- hdl/smc_ctrl.sv -----
`timescale 1ns / 1ps
module smc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  smc_pkg::dp_flags_t flags,
	output smc_pkg::dp_cmd_t   cmd
);
	import smc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_COPY_RD,
		S_COPY_WR,
		S_CLEAR,
		S_CMP_SEL,
		S_RESULT
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   need_id, fire;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign need_id   = flags.kind == K_SET_PROC || flags.kind == K_SWAP_OUT
		|| flags.kind == K_SWAP_IN || flags.kind == K_QUERY;
	assign fire      = (state_q == S_RESULT) && (!out_valid_q || out_ready);

	always_comb begin
		cmd.op      = CMD_NONE;
		cmd.st_we   = 1'b0;
		cmd.st_code = ST_OK;
		state_d     = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = CMD_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_RESULT;
				if (need_id && !flags.id_ok) begin
					cmd.st_we   = 1'b1;
					cmd.st_code = ST_BAD;
				end else begin
					unique case (flags.kind)
						K_WRITE_RAM: begin
							if (flags.ram_addr_ok) begin
								cmd.op = CMD_WRITE_RAM;
							end else begin
								cmd.st_we   = 1'b1;
								cmd.st_code = ST_BAD;
							end
						end
						K_READ_RAM: begin
							if (!flags.ram_addr_ok) begin
								cmd.st_we   = 1'b1;
								cmd.st_code = ST_BAD;
							end
						end
						K_READ_DISK: begin
							if (!flags.disk_addr_ok) begin
								cmd.st_we   = 1'b1;
								cmd.st_code = ST_BAD;
							end
						end
						K_SET_PROC: begin
							if (flags.region_ok) begin
								cmd.op = CMD_SET_PROC;
							end else begin
								cmd.st_we   = 1'b1;
								cmd.st_code = ST_BAD;
							end
						end
						K_SWAP_OUT: begin
							if (!flags.resident) begin
								cmd.st_we   = 1'b1;
								cmd.st_code = ST_NOT_RESIDENT;
							end else begin
								cmd.op  = CMD_SCAN_START;
								state_d = S_SCAN;
							end
						end
						K_SWAP_IN: begin
							if (flags.resident) begin
								cmd.st_we   = 1'b1;
								cmd.st_code = ST_RESIDENT;
							end else if (!flags.slot_valid) begin
								cmd.st_we   = 1'b1;
								cmd.st_code = ST_NOT_RESIDENT;
							end else begin
								cmd.op  = CMD_SCAN_START;
								state_d = S_SCAN;
							end
						end
						K_COMPACT: begin
							cmd.op  = CMD_CMP_START;
							state_d = S_CMP_SEL;
						end
						K_QUERY: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				if (flags.scan_free && flags.scan_fits) begin
					cmd.op  = (flags.kind == K_SWAP_OUT) ? CMD_SO_BEGIN : CMD_SI_BEGIN;
					state_d = S_COPY_RD;
				end else if (flags.scan_free || flags.scan_last) begin
					cmd.st_we   = 1'b1;
					cmd.st_code = (flags.kind == K_SWAP_OUT) ? ST_DISK_FULL : ST_NO_SPACE;
					state_d     = S_RESULT;
				end else begin
					cmd.op = CMD_SCAN_STEP;
				end
			end
			S_COPY_RD: begin
				cmd.op  = CMD_COPY_RD;
				state_d = S_COPY_WR;
			end
			S_COPY_WR: begin
				cmd.op = CMD_COPY_WR;
				if (!flags.cnt_last) begin
					state_d = S_COPY_RD;
				end else if (flags.kind == K_COMPACT) begin
					state_d = S_CLEAR;
				end else begin
					state_d = S_RESULT;
				end
			end
			S_CLEAR: begin
				if (flags.clr_done) begin
					state_d = S_CMP_SEL;
				end else begin
					cmd.op = CMD_CLEAR;
				end
			end
			S_CMP_SEL: begin
				if (!flags.cmp_done && flags.cmp_found) begin
					cmd.op  = CMD_CMP_MOVE;
					state_d = flags.cmp_move ? S_COPY_RD : S_CMP_SEL;
				end else begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (fire) begin
					cmd.op  = CMD_RESULT;
					state_d = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/swap_and_compact_memory.sv -----
`timescale 1ns / 1ps
// channel | handshake            | payload
// in      | in_valid / in_ready  | kind proc_id word_address word_data region_first
//         |                      | region_last counter_in code_lines
// out     | out_valid / out_ready| status read_value slot_index start_out end_out
//         |                      | counter_out in_ram
// Word access, set-up and query: accept, then the decode and result steps, then back to idle.
// Swaps scan occupancy one word a cycle to the first free word (disk up to 128, ram 64),
// then move each word by a read and a write step. Compaction picks regions from the table
// until a final pick; a moved region is copied word by word, then its freed words cleared.
// Reset clears all occupancy flags at once: no clearing pass, ready right away.
// A result waiting on out_ready holds the next transaction in its result step.
module swap_and_compact_memory (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [smc_pkg::KIND_W-1:0]   kind,
	input  logic [smc_pkg::ID_W-1:0]     proc_id,
	input  logic [smc_pkg::ADDR_W-1:0]   word_address,
	input  logic [smc_pkg::DATA_W-1:0]   word_data,
	input  logic [smc_pkg::FIELD_W-1:0]  region_first,
	input  logic [smc_pkg::FIELD_W-1:0]  region_last,
	input  logic [smc_pkg::FIELD_W-1:0]  counter_in,
	input  logic [smc_pkg::FIELD_W-1:0]  code_lines,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [smc_pkg::STATUS_W-1:0] status,
	output logic [smc_pkg::DATA_W-1:0]   read_value,
	output logic [smc_pkg::SLOT_W-1:0]   slot_index,
	output logic [smc_pkg::FIELD_W-1:0]  start_out,
	output logic [smc_pkg::FIELD_W-1:0]  end_out,
	output logic [smc_pkg::FIELD_W-1:0]  counter_out,
	output logic                         in_ram
);
	import smc_pkg::*;

	dp_cmd_t   cmd;
	dp_flags_t flags;

	smc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.flags     (flags),
		.cmd       (cmd)
	);

	smc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.flags        (flags),
		.kind         (kind),
		.proc_id      (proc_id),
		.word_address (word_address),
		.word_data    (word_data),
		.region_first (region_first),
		.region_last  (region_last),
		.counter_in   (counter_in),
		.code_lines   (code_lines),
		.status       (status),
		.read_value   (read_value),
		.slot_index   (slot_index),
		.start_out    (start_out),
		.end_out      (end_out),
		.counter_out  (counter_out),
		.in_ram       (in_ram)
	);

endmodule
